>>> rtl/quad_mesh_triangulator_core_defines.svh
// ----------------------------------------------------------------------------
// quad mesh triangulator assertion macros
// concurrent check helpers clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef QUAD_MESH_TRIANGULATOR_CORE_DEFINES_SVH
`define QUAD_MESH_TRIANGULATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define QMT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define QMT_ASSERT_IMPL(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);
`else
`define QMT_ASSERT(name, prop, msg)
`define QMT_ASSERT_IMPL(name, cond, prop, msg)
`endif

`endif

>>> rtl/qmt_pkg.sv
// ----------------------------------------------------------------------------
// qmt_pkg
// shared widths, result codes and controller/datapath structs
// ----------------------------------------------------------------------------
`default_nettype none

package qmt_pkg;

  localparam int unsigned POS_W          = 24;
  localparam int unsigned IDX_W          = 16;
  localparam int unsigned DIFF_W         = POS_W + 1;
  localparam int unsigned MUL_W          = 32;
  localparam int unsigned PROD_W         = 2 * MUL_W;
  localparam int unsigned CROSS_W        = 52;
  localparam int unsigned MAG_W          = CROSS_W - 1;
  localparam int unsigned NORM_LIMIT_BIT = 30;
  localparam int unsigned ROOT_W         = 64;
  localparam int unsigned LEN_W          = 31;
  localparam int unsigned NRM_W          = 16;
  localparam int unsigned QUO_W          = 16;
  localparam int unsigned FRAC_SHIFT     = 15;
  localparam int unsigned DIVR_W         = LEN_W + QUO_W;
  localparam int unsigned STEP_W         = 6;
  localparam int unsigned SEL_W          = 3;

  localparam int unsigned CROSS_STEPS = 6;
  localparam int unsigned SQR_STEPS   = 3;
  localparam int unsigned ROOT_STEPS  = 32;
  localparam int unsigned DIV_STEPS   = QUO_W;
  localparam int unsigned AXES        = 3;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_TRI    = 2'd1;
  localparam logic [1:0] KIND_BOUNDS = 2'd2;

  localparam logic [SEL_W-1:0] SEL_CORNER_LAST = 3'd3;
  localparam logic [SEL_W-1:0] SEL_TRI_A       = 3'd4;
  localparam logic [SEL_W-1:0] SEL_TRI_B       = 3'd5;
  localparam logic [SEL_W-1:0] SEL_BOUNDS      = 3'd6;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIFF,
    OP_CROSS,
    OP_MAG,
    OP_SHIFT,
    OP_SQR,
    OP_ROOT,
    OP_DIV,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic              capture;
    dp_op_e            op;
    logic [STEP_W-1:0] step;
    logic [1:0]        comp;
    logic [SEL_W-1:0]  sel;
    logic              last;
    logic              clear;
  } dp_cmd_t;

  typedef struct packed {
    logic quad_full;
    logic big;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [1:0] kind;
    pos_t       first_x;
    pos_t       first_y;
    pos_t       first_z;
    pos_t       second_x;
    pos_t       second_y;
    pos_t       second_z;
    logic       tex_u;
    logic       tex_v;
    logic       overflow;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/qmt_if.sv
// ----------------------------------------------------------------------------
// qmt channel interfaces
// valid/ready channels for vertex input and mesh result output
// ----------------------------------------------------------------------------
`default_nettype none

interface qmt_in_if;
  logic          valid;
  logic          ready;
  qmt_pkg::pos_t pos_x;
  qmt_pkg::pos_t pos_y;
  qmt_pkg::pos_t pos_z;
  logic          mesh_end;

  modport source (output valid, pos_x, pos_y, pos_z, mesh_end, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, mesh_end, output ready);
endinterface

interface qmt_out_if;
  logic          valid;
  logic          ready;
  logic [1:0]    kind;
  qmt_pkg::pos_t first_x;
  qmt_pkg::pos_t first_y;
  qmt_pkg::pos_t first_z;
  qmt_pkg::pos_t second_x;
  qmt_pkg::pos_t second_y;
  qmt_pkg::pos_t second_z;
  logic          tex_u;
  logic          tex_v;
  logic          overflow;
  logic          last;

  modport source (output valid, kind, first_x, first_y, first_z, second_x, second_y,
                  second_z, tex_u, tex_v, overflow, last, input ready);
  modport sink   (input valid, kind, first_x, first_y, first_z, second_x, second_y,
                  second_z, tex_u, tex_v, overflow, last, output ready);
endinterface

`default_nettype wire

>>> rtl/qmt_datapath.sv
// ----------------------------------------------------------------------------
// qmt_datapath
// quad store, shared multiplier, normal unit, bounding box and output register
// ----------------------------------------------------------------------------
`default_nettype none

module qmt_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire qmt_pkg::dp_cmd_t    cmd_i,
  output qmt_pkg::dp_status_t      status_o,
  input  wire qmt_pkg::pos_t       pos_x_i,
  input  wire qmt_pkg::pos_t       pos_y_i,
  input  wire qmt_pkg::pos_t       pos_z_i,
  output qmt_pkg::result_t         res_o,
  output logic                     res_valid_o,
  input  wire logic                res_ready_i
);

  qmt_pkg::pos_t px_q [4];
  qmt_pkg::pos_t py_q [4];
  qmt_pkg::pos_t pz_q [4];
  logic [1:0]    slot_q;
  logic [qmt_pkg::IDX_W-1:0] base_q;
  logic          ovf_q;
  logic          box_valid_q;
  qmt_pkg::pos_t box_min_q [qmt_pkg::AXES];
  qmt_pkg::pos_t box_max_q [qmt_pkg::AXES];

  logic signed [qmt_pkg::DIFF_W-1:0]  a_q [qmt_pkg::AXES];
  logic signed [qmt_pkg::DIFF_W-1:0]  b_q [qmt_pkg::AXES];
  logic signed [qmt_pkg::PROD_W-1:0]  prod_q;
  logic signed [qmt_pkg::CROSS_W-1:0] cr_q [qmt_pkg::AXES];
  logic [qmt_pkg::MAG_W-1:0]          u_q [qmt_pkg::AXES];
  logic [qmt_pkg::ROOT_W-1:0]         sum_q;
  logic [qmt_pkg::ROOT_W-1:0]         r_q;
  logic [qmt_pkg::DIVR_W-1:0]         rem_q;
  logic [qmt_pkg::DIVR_W-1:0]         dv_q;
  logic [qmt_pkg::QUO_W-1:0]          quo_q;
  logic signed [qmt_pkg::NRM_W-1:0]   nrm_q [qmt_pkg::AXES];
  qmt_pkg::result_t                   res_q;
  logic                               res_valid_q;

  logic signed [qmt_pkg::MUL_W-1:0]  mul_a;
  logic signed [qmt_pkg::MUL_W-1:0]  mul_b;
  logic signed [qmt_pkg::PROD_W-1:0] mul_p;
  logic [qmt_pkg::STEP_W-1:0]        s1;
  logic [1:0]                        acc_idx;
  logic [6:0]                        root_sh;
  logic [qmt_pkg::ROOT_W-1:0]        root_bit;
  logic [qmt_pkg::ROOT_W-1:0]        root_t;
  logic [qmt_pkg::LEN_W-1:0]         len;
  logic                              div_ge;
  logic [qmt_pkg::QUO_W-1:0]         quo_n;
  logic [qmt_pkg::MAG_W-1:0]         u_sel;
  logic [1:0]                        vsel;
  qmt_pkg::pos_t                     vx, vy, vz;
  logic [qmt_pkg::IDX_W-1:0]         i0, i1, i2;
  qmt_pkg::pos_t                     cen [qmt_pkg::AXES];
  qmt_pkg::pos_t                     ext [qmt_pkg::AXES];
  logic signed [qmt_pkg::DIFF_W-1:0] bsum, bext;
  logic                              load;

  assign load = (cmd_i.op == qmt_pkg::OP_EMIT);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == qmt_pkg::OP_CROSS) begin
      case (cmd_i.step)
        6'd0: begin mul_a = qmt_pkg::MUL_W'(a_q[1]); mul_b = qmt_pkg::MUL_W'(b_q[2]); end
        6'd1: begin mul_a = qmt_pkg::MUL_W'(a_q[2]); mul_b = qmt_pkg::MUL_W'(b_q[1]); end
        6'd2: begin mul_a = qmt_pkg::MUL_W'(a_q[2]); mul_b = qmt_pkg::MUL_W'(b_q[0]); end
        6'd3: begin mul_a = qmt_pkg::MUL_W'(a_q[0]); mul_b = qmt_pkg::MUL_W'(b_q[2]); end
        6'd4: begin mul_a = qmt_pkg::MUL_W'(a_q[0]); mul_b = qmt_pkg::MUL_W'(b_q[1]); end
        6'd5: begin mul_a = qmt_pkg::MUL_W'(a_q[1]); mul_b = qmt_pkg::MUL_W'(b_q[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (cmd_i.op == qmt_pkg::OP_SQR) begin
      case (cmd_i.step)
        6'd0:    u_sel = u_q[0];
        6'd1:    u_sel = u_q[1];
        6'd2:    u_sel = u_q[2];
        default: u_sel = '0;
      endcase
      mul_a = $signed({{(qmt_pkg::MUL_W-qmt_pkg::NORM_LIMIT_BIT){1'b0}},
                       u_sel[qmt_pkg::NORM_LIMIT_BIT-1:0]});
      mul_b = mul_a;
    end
    if (cmd_i.op != qmt_pkg::OP_SQR) begin
      u_sel = '0;
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign s1      = cmd_i.step - qmt_pkg::STEP_W'(1);
  assign acc_idx = s1[2:1];

  // integer square root step
  assign root_sh  = 7'(2 * qmt_pkg::ROOT_STEPS - 2) - {cmd_i.step, 1'b0};
  assign root_bit = qmt_pkg::ROOT_W'(1) << root_sh;
  assign root_t   = r_q + root_bit;
  assign len      = r_q[qmt_pkg::LEN_W-1:0];

  // restoring divider step
  assign div_ge = (rem_q >= dv_q);
  assign quo_n  = {quo_q[qmt_pkg::QUO_W-2:0], div_ge};

  // result selection
  assign vsel = cmd_i.sel[1:0];
  assign vx   = px_q[vsel];
  assign vy   = py_q[vsel];
  assign vz   = pz_q[vsel];
  assign i0   = base_q + ((cmd_i.sel == qmt_pkg::SEL_TRI_A) ? qmt_pkg::IDX_W'(0)
                                                           : qmt_pkg::IDX_W'(3));
  assign i1   = base_q + qmt_pkg::IDX_W'(1);
  assign i2   = base_q + ((cmd_i.sel == qmt_pkg::SEL_TRI_A) ? qmt_pkg::IDX_W'(3)
                                                           : qmt_pkg::IDX_W'(2));

  always_comb begin
    bsum = '0;
    bext = '0;
    for (int i = 0; i < qmt_pkg::AXES; i++) begin
      bsum   = qmt_pkg::DIFF_W'(box_min_q[i]) + qmt_pkg::DIFF_W'(box_max_q[i]);
      cen[i] = qmt_pkg::POS_W'(bsum >>> 1);
      bext   = qmt_pkg::DIFF_W'(box_max_q[i]) - qmt_pkg::DIFF_W'(cen[i]);
      if (bext[qmt_pkg::DIFF_W-1:qmt_pkg::POS_W-1] != 2'b00) begin
        ext[i] = {1'b0, {(qmt_pkg::POS_W-1){1'b1}}};
      end else begin
        ext[i] = qmt_pkg::POS_W'(bext);
      end
      if (!box_valid_q) begin
        cen[i] = '0;
        ext[i] = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      base_q      <= '0;
      ovf_q       <= 1'b0;
      box_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        slot_q <= slot_q + 2'd1;
        if (slot_q == 2'd3) begin
          ovf_q <= ovf_q | (&base_q[qmt_pkg::IDX_W-1:2]);
        end
      end
      if (load) begin
        res_valid_q <= 1'b1;
        if (cmd_i.sel <= qmt_pkg::SEL_CORNER_LAST) begin
          box_valid_q <= 1'b1;
        end
        if (cmd_i.sel == qmt_pkg::SEL_TRI_B) begin
          base_q <= base_q + qmt_pkg::IDX_W'(4);
        end
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        slot_q      <= '0;
        base_q      <= '0;
        ovf_q       <= 1'b0;
        box_valid_q <= 1'b0;
      end
    end
  end

  // payload and arithmetic
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (cmd_i.capture) begin
      px_q[slot_q] <= pos_x_i;
      py_q[slot_q] <= pos_y_i;
      pz_q[slot_q] <= pos_z_i;
    end
    case (cmd_i.op)
      qmt_pkg::OP_DIFF: begin
        a_q[0] <= qmt_pkg::DIFF_W'(px_q[1]) - qmt_pkg::DIFF_W'(px_q[0]);
        a_q[1] <= qmt_pkg::DIFF_W'(py_q[1]) - qmt_pkg::DIFF_W'(py_q[0]);
        a_q[2] <= qmt_pkg::DIFF_W'(pz_q[1]) - qmt_pkg::DIFF_W'(pz_q[0]);
        b_q[0] <= qmt_pkg::DIFF_W'(px_q[2]) - qmt_pkg::DIFF_W'(px_q[0]);
        b_q[1] <= qmt_pkg::DIFF_W'(py_q[2]) - qmt_pkg::DIFF_W'(py_q[0]);
        b_q[2] <= qmt_pkg::DIFF_W'(pz_q[2]) - qmt_pkg::DIFF_W'(pz_q[0]);
        for (int i = 0; i < qmt_pkg::AXES; i++) begin
          cr_q[i] <= '0;
        end
      end
      qmt_pkg::OP_CROSS: begin
        if (cmd_i.step != '0) begin
          if (s1[0]) begin
            cr_q[acc_idx] <= cr_q[acc_idx] - $signed(prod_q[qmt_pkg::CROSS_W-1:0]);
          end else begin
            cr_q[acc_idx] <= cr_q[acc_idx] + $signed(prod_q[qmt_pkg::CROSS_W-1:0]);
          end
        end
      end
      qmt_pkg::OP_MAG: begin
        for (int i = 0; i < qmt_pkg::AXES; i++) begin
          if (cr_q[i][qmt_pkg::CROSS_W-1]) begin
            u_q[i] <= qmt_pkg::MAG_W'(-cr_q[i]);
          end else begin
            u_q[i] <= qmt_pkg::MAG_W'(cr_q[i]);
          end
        end
        sum_q <= '0;
        r_q   <= '0;
      end
      qmt_pkg::OP_SHIFT: begin
        for (int i = 0; i < qmt_pkg::AXES; i++) begin
          u_q[i] <= u_q[i] >> 1;
        end
      end
      qmt_pkg::OP_SQR: begin
        if (cmd_i.step != '0) begin
          sum_q <= sum_q + prod_q;
        end
      end
      qmt_pkg::OP_ROOT: begin
        if (sum_q >= root_t) begin
          sum_q <= sum_q - root_t;
          r_q   <= (r_q >> 1) + root_bit;
        end else begin
          r_q   <= r_q >> 1;
        end
      end
      qmt_pkg::OP_DIV: begin
        if (cmd_i.step == '0) begin
          rem_q <= qmt_pkg::DIVR_W'({u_q[cmd_i.comp][qmt_pkg::NORM_LIMIT_BIT-1:0],
                                     {qmt_pkg::FRAC_SHIFT{1'b0}}})
                   + qmt_pkg::DIVR_W'(len);
          dv_q  <= {len, {qmt_pkg::QUO_W{1'b0}}};
          quo_q <= '0;
        end else begin
          if (div_ge) begin
            rem_q <= rem_q - dv_q;
          end
          dv_q  <= dv_q >> 1;
          quo_q <= quo_n;
          if (cmd_i.step == qmt_pkg::STEP_W'(qmt_pkg::DIV_STEPS)) begin
            if (len == '0) begin
              nrm_q[cmd_i.comp] <= '0;
            end else if (cr_q[cmd_i.comp][qmt_pkg::CROSS_W-1]) begin
              nrm_q[cmd_i.comp] <= -$signed(quo_n);
            end else begin
              nrm_q[cmd_i.comp] <= $signed(quo_n);
            end
          end
        end
      end
      qmt_pkg::OP_EMIT: begin
        res_q.overflow <= ovf_q;
        res_q.last     <= cmd_i.last;
        if (cmd_i.sel <= qmt_pkg::SEL_CORNER_LAST) begin
          res_q.kind     <= qmt_pkg::KIND_VERTEX;
          res_q.first_x  <= vx;
          res_q.first_y  <= vy;
          res_q.first_z  <= vz;
          res_q.second_x <= qmt_pkg::POS_W'(nrm_q[0]);
          res_q.second_y <= qmt_pkg::POS_W'(nrm_q[1]);
          res_q.second_z <= qmt_pkg::POS_W'(nrm_q[2]);
          res_q.tex_u    <= vsel[1];
          res_q.tex_v    <= ~(vsel[1] ^ vsel[0]);
          if (!box_valid_q || vx < box_min_q[0]) box_min_q[0] <= vx;
          if (!box_valid_q || vy < box_min_q[1]) box_min_q[1] <= vy;
          if (!box_valid_q || vz < box_min_q[2]) box_min_q[2] <= vz;
          if (!box_valid_q || vx > box_max_q[0]) box_max_q[0] <= vx;
          if (!box_valid_q || vy > box_max_q[1]) box_max_q[1] <= vy;
          if (!box_valid_q || vz > box_max_q[2]) box_max_q[2] <= vz;
        end else if (cmd_i.sel == qmt_pkg::SEL_BOUNDS) begin
          res_q.kind     <= qmt_pkg::KIND_BOUNDS;
          res_q.first_x  <= cen[0];
          res_q.first_y  <= cen[1];
          res_q.first_z  <= cen[2];
          res_q.second_x <= ext[0];
          res_q.second_y <= ext[1];
          res_q.second_z <= ext[2];
          res_q.tex_u    <= 1'b0;
          res_q.tex_v    <= 1'b0;
        end else begin
          res_q.kind     <= qmt_pkg::KIND_TRI;
          res_q.first_x  <= qmt_pkg::POS_W'(i0);
          res_q.first_y  <= qmt_pkg::POS_W'(i1);
          res_q.first_z  <= qmt_pkg::POS_W'(i2);
          res_q.second_x <= '0;
          res_q.second_y <= '0;
          res_q.second_z <= '0;
          res_q.tex_u    <= 1'b0;
          res_q.tex_v    <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign status_o.quad_full = (slot_q == 2'd3);
  assign status_o.big       = (|u_q[0][qmt_pkg::MAG_W-1:qmt_pkg::NORM_LIMIT_BIT])
                            | (|u_q[1][qmt_pkg::MAG_W-1:qmt_pkg::NORM_LIMIT_BIT])
                            | (|u_q[2][qmt_pkg::MAG_W-1:qmt_pkg::NORM_LIMIT_BIT]);
  assign status_o.out_busy  = res_valid_q & ~res_ready_i;
  assign res_o              = res_q;
  assign res_valid_o        = res_valid_q;

endmodule

`default_nettype wire

>>> rtl/qmt_ctrl.sv
// ----------------------------------------------------------------------------
// qmt_ctrl
// sequencer for vertex capture, normal computation and result emission
// ----------------------------------------------------------------------------
`default_nettype none

module qmt_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_mesh_end_i,
  output logic                      in_ready_o,
  input  wire qmt_pkg::dp_status_t  status_i,
  output qmt_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CROSS,
    ST_MAG,
    ST_NORM,
    ST_SQR,
    ST_ROOT,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                      state_q;
  logic [qmt_pkg::STEP_W-1:0]  cnt_q;
  logic [1:0]                  comp_q;
  logic [qmt_pkg::SEL_W-1:0]   sel_q;
  logic                        end_q;
  logic                        ready_q;
  logic                        accept;
  logic                        final_sel;

  assign accept    = in_valid_i & ready_q;
  assign final_sel = (sel_q == qmt_pkg::SEL_BOUNDS)
                   | ((sel_q == qmt_pkg::SEL_TRI_B) & ~end_q);

  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = qmt_pkg::OP_NONE;
    cmd_o.capture = accept;
    cmd_o.step    = cnt_q;
    cmd_o.comp    = comp_q;
    cmd_o.sel     = sel_q;
    case (state_q)
      ST_DIFF:  cmd_o.op = qmt_pkg::OP_DIFF;
      ST_CROSS: cmd_o.op = qmt_pkg::OP_CROSS;
      ST_MAG:   cmd_o.op = qmt_pkg::OP_MAG;
      ST_NORM:  cmd_o.op = status_i.big ? qmt_pkg::OP_SHIFT : qmt_pkg::OP_NONE;
      ST_SQR:   cmd_o.op = qmt_pkg::OP_SQR;
      ST_ROOT:  cmd_o.op = qmt_pkg::OP_ROOT;
      ST_DIV:   cmd_o.op = qmt_pkg::OP_DIV;
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.op    = qmt_pkg::OP_EMIT;
          cmd_o.last  = final_sel;
          cmd_o.clear = (sel_q == qmt_pkg::SEL_BOUNDS);
        end
      end
      default:  cmd_o.op = qmt_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      sel_q   <= '0;
      end_q   <= 1'b0;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            end_q <= in_mesh_end_i;
            if (status_i.quad_full) begin
              state_q <= ST_DIFF;
              ready_q <= 1'b0;
            end else if (in_mesh_end_i) begin
              state_q <= ST_EMIT;
              sel_q   <= qmt_pkg::SEL_BOUNDS;
              ready_q <= 1'b0;
            end
          end
        end
        ST_DIFF: begin
          state_q <= ST_CROSS;
          cnt_q   <= '0;
        end
        ST_CROSS: begin
          if (cnt_q == qmt_pkg::STEP_W'(qmt_pkg::CROSS_STEPS)) begin
            state_q <= ST_MAG;
          end else begin
            cnt_q <= cnt_q + qmt_pkg::STEP_W'(1);
          end
        end
        ST_MAG: state_q <= ST_NORM;
        ST_NORM: begin
          if (!status_i.big) begin
            state_q <= ST_SQR;
            cnt_q   <= '0;
          end
        end
        ST_SQR: begin
          if (cnt_q == qmt_pkg::STEP_W'(qmt_pkg::SQR_STEPS)) begin
            state_q <= ST_ROOT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + qmt_pkg::STEP_W'(1);
          end
        end
        ST_ROOT: begin
          if (cnt_q == qmt_pkg::STEP_W'(qmt_pkg::ROOT_STEPS - 1)) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
            comp_q  <= '0;
          end else begin
            cnt_q <= cnt_q + qmt_pkg::STEP_W'(1);
          end
        end
        ST_DIV: begin
          if (cnt_q == qmt_pkg::STEP_W'(qmt_pkg::DIV_STEPS)) begin
            cnt_q <= '0;
            if (comp_q == 2'(qmt_pkg::AXES - 1)) begin
              state_q <= ST_EMIT;
              sel_q   <= '0;
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end else begin
            cnt_q <= cnt_q + qmt_pkg::STEP_W'(1);
          end
        end
        ST_EMIT: begin
          if (!status_i.out_busy) begin
            if (final_sel) begin
              state_q <= ST_IDLE;
              ready_q <= 1'b1;
            end else if (sel_q == qmt_pkg::SEL_TRI_B) begin
              sel_q <= qmt_pkg::SEL_BOUNDS;
            end else begin
              sel_q <= sel_q + qmt_pkg::SEL_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

>>> rtl/quad_mesh_triangulator_core.sv
// ----------------------------------------------------------------------------
// quad_mesh_triangulator_core
// groups vertices into quads, emits flat-normal vertices, triangles and bounds
// ----------------------------------------------------------------------------
// channel  dir  transaction
// in_i     in   one vertex position with mesh end flag
// out_o    out  one vertex, triangle or bounds result
//
// a vertex that does not finish a quad or end the mesh is stored while the core stays ready
// a finished quad runs these steps until its last result is registered:
// cross product on the shared multiplier, up to 19 normalising shifts, a
// 32-step square root and three divider passes, then one result per cycle
// while out_o is not stalled
// a mesh end without a quad goes straight to the bounds transaction
// rst_ni clears the quad slot, vertex base, overflow flag and bounds state
`default_nettype none
`include "quad_mesh_triangulator_core_defines.svh"

module quad_mesh_triangulator_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qmt_in_if.sink     in_i,
  qmt_out_if.source  out_o
);

  qmt_pkg::dp_cmd_t    cmd;
  qmt_pkg::dp_status_t status;
  qmt_pkg::result_t    res;
  logic                res_valid;
  logic                out_bounds;
  logic                out_tri;
  logic                tri_clean;
  logic                emit_now;

  qmt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_mesh_end_i (in_i.mesh_end),
    .in_ready_o    (in_i.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  qmt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .pos_x_i     (in_i.pos_x),
    .pos_y_i     (in_i.pos_y),
    .pos_z_i     (in_i.pos_z),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (out_o.ready)
  );

  assign out_o.valid    = res_valid;
  assign out_o.kind     = res.kind;
  assign out_o.first_x  = res.first_x;
  assign out_o.first_y  = res.first_y;
  assign out_o.first_z  = res.first_z;
  assign out_o.second_x = res.second_x;
  assign out_o.second_y = res.second_y;
  assign out_o.second_z = res.second_z;
  assign out_o.tex_u    = res.tex_u;
  assign out_o.tex_v    = res.tex_v;
  assign out_o.overflow = res.overflow;
  assign out_o.last     = res.last;

  assign out_bounds = res_valid & (res.kind == qmt_pkg::KIND_BOUNDS);
  assign out_tri    = res_valid & (res.kind == qmt_pkg::KIND_TRI);
  assign tri_clean  = (res.second_x == '0) & (res.second_y == '0) & (res.second_z == '0)
                    & ~res.tex_u & ~res.tex_v;
  assign emit_now   = (cmd.op == qmt_pkg::OP_EMIT);

  `QMT_ASSERT_IMPL(a_bounds_last, out_bounds, res.last, "bounds result not marked last")
  `QMT_ASSERT_IMPL(a_tri_zero, out_tri, tri_clean, "triangle result carries normal data")
  `QMT_ASSERT(a_no_emit_while_ready, !(in_i.ready && emit_now), "emit while accepting input")

endmodule

`default_nettype wire
